// File: design/cfmb_pkg.sv
// Package: constants, codes and controller/datapath interface types of the frame builder.
package cfmb_pkg;

	localparam int PAYLOAD_DEPTH = 48;
	localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int SEQ_W = $clog2(PAYLOAD_DEPTH + 12);

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENDER_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd2;

	localparam logic [15:0] MAX_FRAME_RESET = 16'd64;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam logic [7:0] CRC8_INIT = 8'hFF;
	localparam logic [7:0] CRC8_POLY = 8'h8C;
	localparam logic [15:0] LEN_OFFSET = 16'd32771; // two CRC bytes plus 32769
	localparam logic [16:0] FRAME_OVERHEAD = 17'd16;

	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_ETX = 8'h03;

	// sequence counter end points
	localparam int HDR_CRC_LAST = 6; // seven header bytes under CRC-8
	localparam int HDR_START = 3; // header follows the three start bytes
	localparam int PRE_LAST = 10; // start bytes plus header
	localparam int POST_LAST = 4; // CRC-16 bytes plus end bytes

	typedef enum logic [1:0] {
		ST_FRAME = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_PRE = 2'd0,
		SEL_PAY = 2'd1,
		SEL_POST = 2'd2,
		SEL_ERR = 2'd3
	} sel_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_CHECK = 3'd1,
		S_CRC8 = 3'd2,
		S_PRE = 3'd3,
		S_PAY = 3'd4,
		S_POST = 3'd5,
		S_ERR = 3'd6
	} state_t;

	typedef struct packed {
		logic accept;
		logic crc8_init;
		logic crc8_step;
		logic cnt_clr;
		logic cnt_inc;
		logic load;
		sel_t sel;
		logic clear_msg;
	} cmd_t;

	typedef struct packed {
		logic [SEQ_W-1:0] cnt;
		logic [CNT_W-1:0] count;
		logic overflowed;
		logic too_long;
		logic out_free;
		logic pay_last;
	} sts_t;

endpackage

// File: design/crc_framed_message_builder_core.sv
// Top level: framed message builder with CRC-8 header and CRC-16 payload check.
//
//  channel   | direction | words                       | fields
//  ----------+-----------+-----------------------------+---------------------------------
//  cfg       | in        | register writes             | index 0 network, 1 sender, 2 max len
//  s_axis    | in        | payload bytes, one per word | data, present, last, header fields
//  m_axis    | out       | frame bytes or error word   | byte, frame end, status
//
// Payload words are taken at one per cycle while collecting. After the last word the
// block runs the length check and then the header CRC-8 (one header byte per cycle),
// then sends n+16 frame words at one per cycle while the output is not stalled, the
// store read one address ahead. The input is held off from the last word until the
// final frame word is loaded into the output register.
// Reset clears control state and config registers only; the payload store needs no clearing pass.
// A stall on the output simply holds the sequencer; nothing is dropped.
module crc_framed_message_builder_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [cfmb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cfmb_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// [7:0] data_byte, [15:8] receiver_id, [23:16] message_id, [24] need_ack, [25] is_ack
	input logic [cfmb_pkg::S_TDATA_W-1:0] s_tdata,
	input logic s_tlast,
	// [0] byte_present
	input logic [cfmb_pkg::S_TUSER_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// [7:0] frame_byte
	output logic [cfmb_pkg::M_TDATA_W-1:0] m_tdata,
	output logic m_tlast,
	// [1:0] status
	output logic [cfmb_pkg::M_TUSER_W-1:0] m_tuser
);
	import cfmb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: decides when words are taken and which frame byte goes out next
	cfmb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast(s_tlast),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	// storage, CRC units, header build and the output word register
	cfmb_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.cmd(cmd),
		.sts(sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

// File: design/cfmb_ram.sv
// Generic single-port-write, registered-read RAM.
module cfmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/cfmb_datapath.sv
// Datapath: config registers, payload store, CRC units, header and output word register.
module cfmb_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [cfmb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cfmb_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic [cfmb_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [cfmb_pkg::S_TUSER_W-1:0] s_tuser,
	input logic s_tlast,
	input cfmb_pkg::cmd_t cmd,
	output cfmb_pkg::sts_t sts,
	output logic m_tvalid,
	input logic m_tready,
	output logic [cfmb_pkg::M_TDATA_W-1:0] m_tdata,
	output logic m_tlast,
	output logic [cfmb_pkg::M_TUSER_W-1:0] m_tuser
);
	import cfmb_pkg::*;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ({1'b0, c[7:1]} ^ CRC8_POLY) : {1'b0, c[7:1]};
		end
		return c;
	endfunction

	logic [7:0] net_q, snd_q;
	logic [15:0] maxlen_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0] crc16_q;
	logic ovf_q;
	logic [7:0] rx_q, mid_q;
	logic need_ack_q, is_ack_q;
	logic [7:0] crc8_q;
	logic [SEQ_W-1:0] cnt_q, cnt_next, cnt_hdr;
	logic m_tvalid_q, m_tlast_q;
	logic [7:0] m_tdata_q;
	status_t m_tuser_q;

	logic [7:0] in_byte;
	logic present, room, wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0] rd_data;
	logic [2:0] hdr_idx;
	logic [7:0] hdr_byte, flags, crc8_fin;
	logic [15:0] len_field, crc16_fin;
	logic out_free;
	logic [7:0] nxt_byte;
	logic nxt_last;
	status_t nxt_st;

	assign in_byte = s_tdata[7:0];
	assign present = s_tuser[0];
	assign room = (count_q < CNT_W'(PAYLOAD_DEPTH));
	assign wr_en = cmd.accept && present && room;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q <= '0;
			snd_q <= '0;
			maxlen_q <= MAX_FRAME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NETWORK_ID: net_q <= cfg_data[7:0];
				CFG_SENDER_ID: snd_q <= cfg_data[7:0];
				CFG_MAX_FRAME_LEN: maxlen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc16_q <= CRC16_INIT;
			ovf_q <= 1'b0;
		end else if (cmd.clear_msg) begin
			count_q <= '0;
			crc16_q <= CRC16_INIT;
			ovf_q <= 1'b0;
		end else if (cmd.accept && present) begin
			if (room) begin
				count_q <= count_q + CNT_W'(1);
				crc16_q <= crc16_byte(crc16_q, in_byte);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// header fields sampled on the last word
	always_ff @(posedge clk) begin
		if (cmd.accept && s_tlast) begin
			rx_q <= s_tdata[15:8];
			mid_q <= s_tdata[23:16];
			need_ack_q <= s_tdata[24];
			is_ack_q <= s_tdata[25];
		end
	end

	cfmb_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(in_byte),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// sequence counter; the store is read ahead at the next count
	always_comb begin
		if (cmd.cnt_clr) begin
			cnt_next = '0;
		end else if (cmd.cnt_inc) begin
			cnt_next = cnt_q + SEQ_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
	end

	assign rd_addr = (cnt_next < SEQ_W'(PAYLOAD_DEPTH)) ? cnt_next[ADDR_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	// header bytes
	assign len_field = 16'(count_q) + LEN_OFFSET;
	assign flags = {1'b1, 4'b0000, is_ack_q, need_ack_q && (rx_q != 8'h00), 1'b0};
	assign crc8_fin = (crc8_q == 8'h00) ? 8'h01 : crc8_q;
	assign crc16_fin = (crc16_q == 16'h0000) ? 16'h0001 : crc16_q;
	assign cnt_hdr = cnt_q - SEQ_W'(HDR_START);
	assign hdr_idx = cmd.crc8_step ? cnt_q[2:0] : cnt_hdr[2:0];

	always_comb begin
		case (hdr_idx)
			3'd0: hdr_byte = net_q + 8'd1;
			3'd1: hdr_byte = snd_q + 8'd1;
			3'd2: hdr_byte = rx_q + 8'd1;
			3'd3: hdr_byte = mid_q + 8'd1;
			3'd4: hdr_byte = flags;
			3'd5: hdr_byte = len_field[7:0];
			3'd6: hdr_byte = len_field[15:8];
			default: hdr_byte = crc8_fin;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc8_q <= CRC8_INIT;
		end else if (cmd.crc8_init) begin
			crc8_q <= CRC8_INIT;
		end else if (cmd.crc8_step) begin
			crc8_q <= crc8_byte(crc8_q, hdr_byte);
		end
	end

	// next output word
	always_comb begin
		nxt_byte = 8'h00;
		nxt_last = 1'b0;
		nxt_st = ST_FRAME;
		case (cmd.sel)
			SEL_PRE: begin
				if (cnt_q == SEQ_W'(1)) begin
					nxt_byte = CH_CR;
				end else if (cnt_q < SEQ_W'(HDR_START)) begin
					nxt_byte = CH_STX;
				end else begin
					nxt_byte = hdr_byte;
				end
			end
			SEL_PAY: nxt_byte = rd_data;
			SEL_POST: begin
				case (cnt_q)
					SEQ_W'(0): nxt_byte = crc16_fin[7:0];
					SEQ_W'(1): nxt_byte = crc16_fin[15:8];
					SEQ_W'(3): nxt_byte = CH_CR;
					default: nxt_byte = CH_ETX;
				endcase
				nxt_last = (cnt_q == SEQ_W'(POST_LAST));
			end
			default: begin
				nxt_last = 1'b1;
				nxt_st = ovf_q ? ST_OVERFLOW : ST_TOO_LONG;
			end
		endcase
	end

	// output word register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= nxt_byte;
			m_tlast_q <= nxt_last;
			m_tuser_q <= nxt_st;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

	always_comb begin
		sts.cnt = cnt_q;
		sts.count = count_q;
		sts.overflowed = ovf_q;
		sts.too_long = ({1'b0, 16'(count_q)} + FRAME_OVERHEAD) > {1'b0, maxlen_q};
		sts.out_free = out_free;
		sts.pay_last = (cnt_q + SEQ_W'(1)) == SEQ_W'(count_q);
	end

`ifndef NO_ASSERTIONS
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CNT_W'(PAYLOAD_DEPTH)))
		else $error("overflow flag set with room left in the store");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!m_tvalid_q || m_tready))
		else $error("output word overwritten before it was taken");
`endif

endmodule

// File: design/cfmb_ctrl.sv
// Controller: sequences collection, length check, header CRC and frame or error-word emission.
module cfmb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tlast,
	output logic s_tready,
	input cfmb_pkg::sts_t sts,
	output cfmb_pkg::cmd_t cmd
);
	import cfmb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.sel = SEL_PRE;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (s_tlast) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.cnt_clr = 1'b1;
				cmd.crc8_init = 1'b1;
				if (sts.overflowed || sts.too_long) begin
					state_d = S_ERR;
				end else begin
					state_d = S_CRC8;
				end
			end
			S_CRC8: begin
				cmd.crc8_step = 1'b1;
				if (sts.cnt == SEQ_W'(HDR_CRC_LAST)) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_PRE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_PRE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.cnt == SEQ_W'(PRE_LAST)) begin
						cmd.cnt_clr = 1'b1;
						state_d = (sts.count == '0) ? S_POST : S_PAY;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			S_PAY: begin
				cmd.sel = SEL_PAY;
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.pay_last) begin
						cmd.cnt_clr = 1'b1;
						state_d = S_POST;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			S_POST: begin
				cmd.sel = SEL_POST;
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.cnt == SEQ_W'(POST_LAST)) begin
						cmd.clear_msg = 1'b1;
						cmd.cnt_clr = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			S_ERR: begin
				cmd.sel = SEL_ERR;
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.clear_msg = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_pay_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAY) |-> (sts.count != '0))
		else $error("payload phase entered with an empty store");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_msg |=> (state_q == S_IDLE))
		else $error("message cleared without returning to idle");
	a_crc8_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRC8) |-> (sts.cnt <= SEQ_W'(HDR_CRC_LAST)))
		else $error("header CRC count ran past the header");
`endif

endmodule
